/* rtl/owse_pkg.sv */
package owse_pkg;

  localparam int MAX_WORD_LENGTH = 5;
  localparam int COORD_LIMIT     = 30;
  localparam int MAX_RESULTS     = 5;

  localparam int MIN_LEN     = 3;
  localparam int SPECIAL_LEN = 5;
  localparam int SPECIAL_POS = 2;

  localparam int COORD_W = 6;
  localparam int CFG_W   = 3;
  localparam int OCNT_W  = 3;
  localparam int KEY_W   = 3 * COORD_W + 1;
  localparam int CNT_W   = $clog2(MAX_WORD_LENGTH + 1);
  localparam int PCNT_W  = $clog2(MAX_WORD_LENGTH);
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);

  localparam logic signed [1:0] SIGN_POS  = 2'sb01;
  localparam logic signed [1:0] SIGN_NEG  = 2'sb11;
  localparam logic signed [1:0] SIGN_ZERO = 2'sb00;

  typedef struct packed {
    logic                      sp;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } mode_t;

  typedef struct packed {
    logic  start;
    logic  ins;
    logic  del;
    mode_t mode;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [1:0] sign;
    logic [OCNT_W-1:0] count;
    logic [RES_W-1:0]  rem;
  } drn_hdr_t;

  // flipping the sign bits turns the signed tuple order into an unsigned compare
  function automatic logic [KEY_W-1:0] mode_key(mode_t m);
    return {~m.x[COORD_W-1], m.x[COORD_W-2:0],
            ~m.y[COORD_W-1], m.y[COORD_W-2:0],
            ~m.z[COORD_W-1], m.z[COORD_W-2:0],
            m.sp};
  endfunction

  function automatic logic [CNT_W-1:0] clamp_len(logic [CFG_W-1:0] wl);
    if (int'(wl) < MIN_LEN) begin
      return CNT_W'(MIN_LEN);
    end else if (int'(wl) > MAX_WORD_LENGTH) begin
      return CNT_W'(MAX_WORD_LENGTH);
    end else begin
      return CNT_W'(wl);
    end
  endfunction

endpackage

/* rtl/owse_cell.sv */
module owse_cell (
  input  logic               clk,
  input  logic               rst,
  input  owse_pkg::cell_ctl_t ctl,
  input  logic               prev_lt,
  input  logic               prev_vld,
  input  owse_pkg::mode_t    prev_data,
  input  logic               next_vld,
  input  owse_pkg::mode_t    next_data,
  output logic               lt,
  output logic               eq,
  output logic               vld_eff,
  output owse_pkg::mode_t    data,
  output logic               vld_next,
  output owse_pkg::mode_t    data_next
);

  logic vld;
  logic [owse_pkg::KEY_W-1:0] own_key;
  logic [owse_pkg::KEY_W-1:0] in_key;

  // the set counts as empty on the first mode of a word
  assign vld_eff = vld & ~ctl.start;
  assign own_key = owse_pkg::mode_key(data);
  assign in_key  = owse_pkg::mode_key(ctl.mode);
  assign lt      = vld_eff && (own_key < in_key);
  assign eq      = vld_eff && (own_key == in_key);

  always_comb begin
    vld_next  = vld_eff;
    data_next = data;
    if (ctl.ins && !lt) begin
      // left neighbor below the mode means this is the insertion slot
      vld_next  = prev_lt ? 1'b1 : prev_vld;
      data_next = prev_lt ? ctl.mode : prev_data;
    end else if (ctl.del && !lt) begin
      vld_next  = next_vld;
      data_next = next_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* rtl/owse_drain.sv */
module owse_drain (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ld_en,
  input  owse_pkg::drn_hdr_t       ld_hdr,
  input  logic                     ld_vld  [owse_pkg::MAX_RESULTS],
  input  owse_pkg::mode_t          ld_data [owse_pkg::MAX_RESULTS],
  output logic                     busy,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // word_sign[1:0], entry_count[4:2], entry_x[10:5], entry_y[16:11],
  // entry_z[22:17], entry_species[23]
  output logic [23:0]              m_tdata,
  // entry_valid[0]
  output logic [0:0]               m_tuser,
  output logic                     m_tlast
);

  logic [owse_pkg::RES_W-1:0] rem;
  logic signed [1:0]          sign;
  logic [owse_pkg::OCNT_W-1:0] count;
  logic                       svld  [owse_pkg::MAX_RESULTS];
  owse_pkg::mode_t            sdata [owse_pkg::MAX_RESULTS];
  owse_pkg::mode_t            head;
  logic                       pop;

  assign busy     = (rem != '0);
  assign m_tvalid = busy;
  assign pop      = m_tvalid & m_tready;
  assign m_tlast  = (rem == owse_pkg::RES_W'(1));
  assign head     = svld[0] ? sdata[0] : '0;
  assign m_tuser  = svld[0];
  assign m_tdata  = {head.sp, head.z, head.y, head.x, count, sign};

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (ld_en) begin
      rem <= ld_hdr.rem;
    end else if (pop) begin
      rem <= rem - owse_pkg::RES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en) begin
      sign  <= ld_hdr.sign;
      count <= ld_hdr.count;
      for (int k = 0; k < owse_pkg::MAX_RESULTS; k++) begin
        svld[k]  <= ld_vld[k];
        sdata[k] <= ld_data[k];
      end
    end else if (pop) begin
      for (int k = 0; k < owse_pkg::MAX_RESULTS - 1; k++) begin
        svld[k]  <= svld[k+1];
        sdata[k] <= sdata[k+1];
      end
      svld[owse_pkg::MAX_RESULTS-1] <= 1'b0;
    end
  end

endmodule

/* rtl/operator_word_sign_evaluator_unit.sv */
// Operator word sign evaluator. Modes of a word arrive one transaction per
// cycle when s_tready is high, last position first; word_length (3 to 5,
// clamped) is latched at a word's first mode. A row of one cell per set
// entry compares each mode with its entry in parallel and shifts the sorted
// set left or right in the same cycle, so non-final modes are always taken
// at one per cycle. The final mode loads the set into an output shift chain
// that sends the sign and the entries, one result per cycle while m_tready
// is high (one result when the set is empty or the word is killed). The
// final mode of the next word is held off until that chain is empty or is
// handing over its last result in the same cycle.
module operator_word_sign_evaluator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // coord_x[5:0], coord_y[11:6], coord_z[17:12], species[18], zero pad
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // word_sign[1:0], entry_count[4:2], entry_x[10:5], entry_y[16:11],
  // entry_z[22:17], entry_species[23]
  output logic [23:0] m_tdata,
  // entry_valid[0]
  output logic [0:0]  m_tuser,
  output logic        m_tlast
);

  localparam int N = owse_pkg::MAX_WORD_LENGTH;
  localparam int R = owse_pkg::MAX_RESULTS;

  logic [owse_pkg::CFG_W-1:0]  word_length;
  logic [owse_pkg::CNT_W-1:0]  cur_len;
  logic [owse_pkg::PCNT_W-1:0] pcnt;
  logic [owse_pkg::CNT_W-1:0]  set_size;
  logic                        running_negative;
  logic                        word_killed;

  owse_pkg::mode_t     mode;
  owse_pkg::cell_ctl_t ctl;
  logic                start, final_pos, create, accept, busy;
  logic [owse_pkg::CNT_W-1:0] len_eff, pos, size_eff, size_next;
  logic                killed_eff, neg_eff, member, kill_now, proc, parity, full;
  logic                neg_next, killed_next;

  logic            lt        [N];
  logic            eq        [N];
  logic            vld_eff   [N];
  owse_pkg::mode_t data      [N];
  logic            vld_next  [N];
  owse_pkg::mode_t data_next [N];
  logic            prev_lt   [N];
  logic            prev_vld  [N];
  owse_pkg::mode_t prev_data [N];
  logic            next_vld  [N];
  owse_pkg::mode_t next_data [N];

  logic [N-1:0]        lt_vec, eq_vec;
  owse_pkg::drn_hdr_t  ld_hdr;
  logic                ld_vld  [R];
  owse_pkg::mode_t     ld_data [R];

  assign mode.x  = s_tdata[5:0];
  assign mode.y  = s_tdata[11:6];
  assign mode.z  = s_tdata[17:12];
  assign mode.sp = s_tdata[18];

  assign start     = (pcnt == '0);
  assign len_eff   = start ? owse_pkg::clamp_len(word_length) : cur_len;
  assign pos       = len_eff - owse_pkg::CNT_W'(1) - owse_pkg::CNT_W'(pcnt);
  assign final_pos = (pos == '0);
  assign create    = final_pos ||
                     ((N >= owse_pkg::SPECIAL_LEN) &&
                      (len_eff == owse_pkg::CNT_W'(owse_pkg::SPECIAL_LEN)) &&
                      (pos == owse_pkg::CNT_W'(owse_pkg::SPECIAL_POS)));

  // the chain may reload in the cycle its last result leaves
  assign s_tready = !final_pos || !busy || (m_tready && m_tlast);
  assign accept   = s_tvalid & s_tready;

  assign killed_eff = word_killed & ~start;
  assign neg_eff    = running_negative & ~start;
  assign size_eff   = start ? '0 : set_size;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      lt_vec[i] = lt[i];
      eq_vec[i] = eq[i];
    end
  end

  assign member   = |eq_vec;
  // parity of x + y + z + species + rank, rank being the count of lower entries
  assign parity   = mode.x[0] ^ mode.y[0] ^ mode.z[0] ^ mode.sp ^ (^lt_vec);
  assign kill_now = (((mode.sp == 1'b0) != member) == create);
  assign proc     = accept & ~killed_eff & ~kill_now;
  assign full     = vld_eff[N-1];

  assign ctl.start = start;
  assign ctl.ins   = proc & ~member & ~full;
  assign ctl.del   = proc & member;
  assign ctl.mode  = mode;

  assign neg_next    = neg_eff ^ (proc & parity);
  assign killed_next = killed_eff | (~killed_eff & kill_now);
  assign size_next   = size_eff + owse_pkg::CNT_W'(ctl.ins) - owse_pkg::CNT_W'(ctl.del);

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_lt[i]   = 1'b1;
      assign prev_vld[i]  = 1'b0;
      assign prev_data[i] = '0;
    end else begin : g_mid
      assign prev_lt[i]   = lt[i-1];
      assign prev_vld[i]  = vld_eff[i-1];
      assign prev_data[i] = data[i-1];
    end
    if (i == N - 1) begin : g_last
      assign next_vld[i]  = 1'b0;
      assign next_data[i] = '0;
    end else begin : g_inner
      assign next_vld[i]  = vld_eff[i+1];
      assign next_data[i] = data[i+1];
    end

    owse_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .prev_lt   (prev_lt[i]),
      .prev_vld  (prev_vld[i]),
      .prev_data (prev_data[i]),
      .next_vld  (next_vld[i]),
      .next_data (next_data[i]),
      .lt        (lt[i]),
      .eq        (eq[i]),
      .vld_eff   (vld_eff[i]),
      .data      (data[i]),
      .vld_next  (vld_next[i]),
      .data_next (data_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length      <= owse_pkg::CFG_W'(owse_pkg::MIN_LEN);
      cur_len          <= owse_pkg::CNT_W'(owse_pkg::MIN_LEN);
      pcnt             <= '0;
      set_size         <= '0;
      running_negative <= 1'b0;
      word_killed      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        word_length <= cfg_wr_data;
      end
      if (accept) begin
        cur_len          <= len_eff;
        pcnt             <= final_pos ? '0 : pcnt + owse_pkg::PCNT_W'(1);
        set_size         <= size_next;
        running_negative <= neg_next;
        word_killed      <= killed_next;
      end
    end
  end

  // snapshot of the final set for the output chain
  always_comb begin
    ld_hdr.sign  = killed_next ? owse_pkg::SIGN_ZERO :
                   (neg_next ? owse_pkg::SIGN_NEG : owse_pkg::SIGN_POS);
    ld_hdr.count = killed_next ? '0 : owse_pkg::OCNT_W'(size_next);
    if (killed_next || size_next == '0) begin
      ld_hdr.rem = owse_pkg::RES_W'(1);
    end else if (int'(size_next) > R) begin
      ld_hdr.rem = owse_pkg::RES_W'(R);
    end else begin
      ld_hdr.rem = owse_pkg::RES_W'(size_next);
    end
    for (int k = 0; k < R; k++) begin
      if (k < N) begin
        ld_vld[k]  = ~killed_next & vld_next[k];
        ld_data[k] = data_next[k];
      end else begin
        ld_vld[k]  = 1'b0;
        ld_data[k] = '0;
      end
    end
  end

  owse_drain u_drain (
    .clk      (clk),
    .rst      (rst),
    .ld_en    (accept & final_pos),
    .ld_hdr   (ld_hdr),
    .ld_vld   (ld_vld),
    .ld_data  (ld_data),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
